### design/slid_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted leaf block.
// No dependencies; every other file imports this package.
package slid_pkg;

  // Leaf capacity and derived sizes
  localparam int unsigned MaxRecords = 32;
  localparam int unsigned MidRecords = (MaxRecords + 1) / 2;
  localparam int unsigned CntW       = $clog2(MaxRecords + 1);
  localparam int unsigned IdxW       = $clog2(MaxRecords);

  // Payload field widths
  localparam int unsigned KeyW    = 64;
  localparam int unsigned PageW   = 31;
  localparam int unsigned SlotW   = 31;
  localparam int unsigned NextW   = 32;
  localparam int unsigned StatusW = 3;

  typedef logic [CntW-1:0] cnt_t;
  typedef logic [IdxW-1:0] idx_t;

  localparam cnt_t MaxCnt    = cnt_t'(MaxRecords);
  localparam cnt_t MidCnt    = cnt_t'(MidRecords);
  localparam cnt_t MidLowCnt = cnt_t'(MidRecords - 1);
  localparam idx_t MidTopIdx = idx_t'(MidRecords - 2);

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_DELETE = 1'b1
  } req_type_e;

  typedef enum logic [StatusW-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOTFOUND  = 3'd3,
    ST_SPLIT     = 3'd4
  } status_e;

  // One leaf record
  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [PageW-1:0]       page;
    logic [SlotW-1:0]       slot;
  } rec_t;

  // Compare unit result: a orders before b, a equals b
  typedef struct packed {
    logic less;
    logic equal;
  } cmp_t;

  // Record memory access bundle
  typedef struct packed {
    logic rd_en;
    idx_t rd_addr;
    logic wr_en;
    idx_t wr_addr;
    rec_t wr_data;
  } mem_req_t;

endpackage

### design/slid_req_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready handshake plus one insert/delete request.
// Depends on slid_pkg.
interface slid_req_if import slid_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic signed [KeyW-1:0] rec_key;
  logic [PageW-1:0]       rec_page;
  logic [SlotW-1:0]       rec_slot;
  logic [PageW-1:0]       fresh_page;

  modport source (output valid, req_type, rec_key, rec_page, rec_slot, fresh_page,
                  input ready);
  modport sink   (input valid, req_type, rec_key, rec_page, rec_slot, fresh_page,
                  output ready);
endinterface

### design/slid_res_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake plus one result transaction.
// Depends on slid_pkg.
interface slid_res_if import slid_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [StatusW-1:0]      status;
  logic signed [KeyW-1:0]  out_key;
  logic [PageW-1:0]        out_page;
  logic [SlotW-1:0]        out_slot;
  logic signed [NextW-1:0] out_next;
  logic                    last;

  modport source (output valid, status, out_key, out_page, out_slot, out_next, last,
                  input ready);
  modport sink   (input valid, status, out_key, out_page, out_slot, out_next, last,
                  output ready);
endinterface

### design/slid_cmp.sv
`timescale 1ns / 1ps
// Shared record compare unit: key (signed), then page, then slot.
// Depends on slid_pkg.
module slid_cmp import slid_pkg::*; (
  input  rec_t a_i,
  input  rec_t b_i,
  output cmp_t cmp_o
);

  logic key_lt, key_eq, page_lt, page_eq, slot_lt, slot_eq;

  // Field compares
  assign key_lt  = $signed(a_i.key) < $signed(b_i.key);
  assign key_eq  = a_i.key == b_i.key;
  assign page_lt = a_i.page < b_i.page;
  assign page_eq = a_i.page == b_i.page;
  assign slot_lt = a_i.slot < b_i.slot;
  assign slot_eq = a_i.slot == b_i.slot;

  // Lexicographic order
  assign cmp_o.less  = key_lt | (key_eq & (page_lt | (page_eq & slot_lt)));
  assign cmp_o.equal = key_eq & page_eq & slot_eq;

endmodule

### design/slid_mem.sv
`timescale 1ns / 1ps
// Leaf record storage: one write port, one read port with registered data.
// Depends on slid_pkg. Contents are undefined until written.
module slid_mem import slid_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t mem_req_i,
  output rec_t     rdata_o
);

  rec_t mem_q [MaxRecords];
  rec_t rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_req_i.wr_en) begin
      mem_q[mem_req_i.wr_addr] <= mem_req_i.wr_data;
    end
    if (mem_req_i.rd_en) begin
      rdata_q <= mem_q[mem_req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/slid_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the leaf: scan, shift, split streaming and result register.
// Depends on slid_pkg, slid_req_if and slid_res_if.
module slid_ctrl import slid_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  slid_req_if.sink   req,
  slid_res_if.source res,
  input  rec_t       rdata_i,
  input  cmp_t       cmp_i,
  output rec_t       rec_o,
  output mem_req_t   mem_req_o
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SCAN   = 9'b000000010,
    S_DECIDE = 9'b000000100,
    S_COPY   = 9'b000001000,
    S_WNEW   = 9'b000010000,
    S_SRD    = 9'b000100000,
    S_SLD    = 9'b001000000,
    S_SOUT   = 9'b010000000,
    S_RESP   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  rec_t   req_q, req_d;
  logic   op_q, op_d;
  logic [PageW-1:0] fresh_q, fresh_d;
  cnt_t   fill_q, fill_d;
  logic [NextW-1:0] next_q, next_d;
  cnt_t   cnt_q, cnt_d;
  cnt_t   idx_q, idx_d;
  logic   hit_q, hit_d;
  logic   split_q, split_d;
  idx_t   cur_q, cur_d;
  logic   left_q, left_d;

  // Result register
  logic [StatusW-1:0] res_status_q, res_status_d;
  rec_t               res_rec_q, res_rec_d;
  logic [NextW-1:0]   res_next_q, res_next_d;
  logic               res_last_q, res_last_d;

  logic    res_simple;
  status_e res_code;
  cnt_t    cnt_inc;
  cnt_t    cur_cnt;

  // Source slot in the old leaf for merged position i during a split
  function automatic idx_t split_src(cnt_t i, cnt_t ins);
    cnt_t j;
    j = (i < ins) ? i : i - 1'b1;
    return idx_t'(j);
  endfunction

  assign cnt_inc = cnt_q + 1'b1;
  assign cur_cnt = cnt_t'(cur_q);
  assign rec_o   = req_q;

  // Channel outputs
  assign req.ready    = (state_q == S_IDLE);
  assign res.valid    = (state_q == S_RESP) || (state_q == S_SOUT);
  assign res.status   = res_status_q;
  assign res.out_key  = res_rec_q.key;
  assign res.out_page = res_rec_q.page;
  assign res.out_slot = res_rec_q.slot;
  assign res.out_next = res_next_q;
  assign res.last     = res_last_q;

  // Next-state logic
  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    op_d         = op_q;
    fresh_d      = fresh_q;
    fill_d       = fill_q;
    next_d       = next_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    hit_d        = hit_q;
    split_d      = split_q;
    cur_d        = cur_q;
    left_d       = left_q;
    res_status_d = res_status_q;
    res_rec_d    = res_rec_q;
    res_next_d   = res_next_q;
    res_last_d   = res_last_q;
    res_simple   = 1'b0;
    res_code     = ST_INSERTED;
    mem_req_o    = '0;
    mem_req_o.wr_data = rdata_i;

    case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          req_d.key  = req.rec_key;
          req_d.page = req.rec_page;
          req_d.slot = req.rec_slot;
          op_d       = req.req_type;
          fresh_d    = req.fresh_page;
          cnt_d      = '0;
          if (fill_q == '0) begin
            idx_d   = '0;
            hit_d   = 1'b0;
            state_d = S_DECIDE;
          end else begin
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = '0;
            state_d           = S_SCAN;
          end
        end
      end

      // One stored record compared per cycle for the lower bound
      S_SCAN: begin
        if (cmp_i.less) begin
          if (cnt_inc == fill_q) begin
            idx_d   = fill_q;
            hit_d   = 1'b0;
            state_d = S_DECIDE;
          end else begin
            cnt_d             = cnt_inc;
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = idx_t'(cnt_inc);
          end
        end else begin
          idx_d   = cnt_q;
          hit_d   = cmp_i.equal;
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (op_q == REQ_DELETE) begin
          if (!hit_q) begin
            res_simple = 1'b1;
            res_code   = ST_NOTFOUND;
            state_d    = S_RESP;
          end else if (idx_q + 1'b1 < fill_q) begin
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = idx_t'(idx_q + 1'b1);
            cur_d             = idx_t'(idx_q + 1'b1);
            left_d            = 1'b1;
            state_d           = S_COPY;
          end else begin
            fill_d     = fill_q - 1'b1;
            res_simple = 1'b1;
            res_code   = ST_DELETED;
            state_d    = S_RESP;
          end
        end else if (hit_q) begin
          res_simple = 1'b1;
          res_code   = ST_DUPLICATE;
          state_d    = S_RESP;
        end else if (fill_q != MaxCnt) begin
          split_d = 1'b0;
          if (idx_q != fill_q) begin
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = idx_t'(fill_q - 1'b1);
            cur_d             = idx_t'(fill_q - 1'b1);
            left_d            = 1'b0;
            state_d           = S_COPY;
          end else begin
            state_d = S_WNEW;
          end
        end else begin
          split_d = 1'b1;
          cnt_d   = MidCnt;
          state_d = S_SRD;
        end
      end

      // Shift one record per cycle; rdata holds the record at cur
      S_COPY: begin
        mem_req_o.wr_en = 1'b1;
        if (left_q) begin
          mem_req_o.wr_addr = cur_q - 1'b1;
          if (cur_cnt + 1'b1 == fill_q) begin
            fill_d     = fill_q - 1'b1;
            res_simple = 1'b1;
            res_code   = ST_DELETED;
            state_d    = S_RESP;
          end else begin
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = cur_q + 1'b1;
            cur_d             = cur_q + 1'b1;
          end
        end else begin
          mem_req_o.wr_addr = cur_q + 1'b1;
          if (cur_cnt == idx_q) begin
            state_d = S_WNEW;
          end else begin
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = cur_q - 1'b1;
            cur_d             = cur_q - 1'b1;
          end
        end
      end

      // Place the new record at the lower-bound slot
      S_WNEW: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = idx_t'(idx_q);
        mem_req_o.wr_data = req_q;
        if (split_q) begin
          fill_d  = MidCnt;
          next_d  = NextW'(fresh_q);
          state_d = S_IDLE;
        end else begin
          fill_d     = fill_q + 1'b1;
          res_simple = 1'b1;
          res_code   = ST_INSERTED;
          state_d    = S_RESP;
        end
      end

      S_SRD: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = split_src(cnt_q, idx_q);
        state_d           = S_SLD;
      end

      // Load one upper-half record of the merged set
      S_SLD: begin
        res_status_d = ST_SPLIT;
        res_rec_d    = (cnt_q == idx_q) ? req_q : rdata_i;
        res_next_d   = next_q;
        res_last_d   = (cnt_q == MaxCnt);
        state_d      = S_SOUT;
      end

      S_SOUT: begin
        if (res.ready) begin
          if (res_last_q) begin
            // Upper half delivered; now fix up the lower half
            if (idx_q < MidLowCnt) begin
              mem_req_o.rd_en   = 1'b1;
              mem_req_o.rd_addr = MidTopIdx;
              cur_d             = MidTopIdx;
              left_d            = 1'b0;
              state_d           = S_COPY;
            end else if (idx_q == MidLowCnt) begin
              state_d = S_WNEW;
            end else begin
              fill_d  = MidCnt;
              next_d  = NextW'(fresh_q);
              state_d = S_IDLE;
            end
          end else begin
            cnt_d             = cnt_inc;
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = split_src(cnt_inc, idx_q);
            state_d           = S_SLD;
          end
        end
      end

      S_RESP: begin
        if (res.ready) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Single-transaction results carry zero payload
    if (res_simple) begin
      res_status_d = res_code;
      res_rec_d    = '0;
      res_next_d   = '0;
      res_last_d   = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      next_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      next_q  <= next_d;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    op_q         <= op_d;
    fresh_q      <= fresh_d;
    cnt_q        <= cnt_d;
    idx_q        <= idx_d;
    hit_q        <= hit_d;
    split_q      <= split_d;
    cur_q        <= cur_d;
    left_q       <= left_d;
    res_status_q <= res_status_d;
    res_rec_q    <= res_rec_d;
    res_next_q   <= res_next_d;
    res_last_q   <= res_last_d;
  end

endmodule

### design/sorted_leaf_insert_delete_split.sv
`timescale 1ns / 1ps
// Sorted B+ tree leaf with insert, delete and split; top level.
// Depends on slid_pkg, slid_req_if, slid_res_if, slid_cmp, slid_mem, slid_ctrl.
//
// Usage:
//   req_i carries one insert or delete request per transaction; res_o returns
//   the results. Insert, duplicate, delete and not-found give one transaction
//   with last set. An insert into a full leaf gives one split transaction per
//   record moved to the new leaf, in ascending order, the final one with last.
//   req_i.ready is high only while the block is idle; one request at a time.
//   The lower-bound scan compares one stored record per cycle through the
//   shared compare unit and is skipped for an empty leaf. A decision step
//   follows; the record memory then shifts any records that move, one per
//   cycle, an insert places the new record, and the result is offered. A
//   split reads the first upper-half record, streams each one through a
//   load and an output step, then shifts the kept lower half as needed and
//   places the new record there when it belongs to the lower half.
//   Reset clears the record count and the next-leaf pointer; stored records
//   need no clearing. When the receiver stalls, the result register holds its
//   transaction and the sequencer waits.
module sorted_leaf_insert_delete_split import slid_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  slid_req_if.sink   req_i,
  slid_res_if.source res_o
);

  mem_req_t mem_req;
  rec_t     rdata;
  rec_t     rec;
  cmp_t     cmp;

  // Record memory
  slid_mem u_mem (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (rdata)
  );

  // Shared compare unit
  slid_cmp u_cmp (
    .a_i   (rdata),
    .b_i   (rec),
    .cmp_o (cmp)
  );

  // Sequencer
  slid_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req_i),
    .res       (res_o),
    .rdata_i   (rdata),
    .cmp_i     (cmp),
    .rec_o     (rec),
    .mem_req_o (mem_req)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the sorted leaf block: random and directed insert/delete traffic.
// A mirror of the leaf predicts every result. Depends on slid_pkg, slid_req_if, slid_res_if
// and the sorted_leaf_insert_delete_split top level.
module tb import slid_pkg::*; ();

  localparam int QuietLimit  = 2000;  // cycles without any transaction before giving up
  localparam int RandomItems = 220;
  localparam int CalmItems   = 40;    // final stretch without idling on either side
  localparam int SettleCycles = 100;

  // One result transaction as seen on res_o
  typedef struct {
    logic [StatusW-1:0]      status;
    logic signed [KeyW-1:0]  key;
    logic [PageW-1:0]        page;
    logic [SlotW-1:0]        slot;
    logic signed [NextW-1:0] nxt;
    logic                    last;
  } leaf_result_t;

  // Mirror of the leaf contents plus the results still owed by the block
  class leaf_tracker;
    rec_t              recs [MaxRecords];
    int                fill;
    logic [NextW-1:0]  next_ptr;
    leaf_result_t      awaited [$];
    int                errors;

    function new();
      fill     = 0;
      next_ptr = '0;
      errors   = 0;
    endfunction

    // key (signed), then page, then slot
    static function bit orders_before(rec_t a, rec_t b);
      if (a.key != b.key) return $signed(a.key) < $signed(b.key);
      if (a.page != b.page) return a.page < b.page;
      return a.slot < b.slot;
    endfunction

    function void push_single(status_e st);
      leaf_result_t one;
      one = '{st, 0, 0, 0, 0, 1'b1};
      awaited.insert(awaited.size(), one);
    endfunction

    // Update the mirror for one accepted request and queue its results
    function void apply_request(req_type_e op, rec_t r, logic [PageW-1:0] fresh);
      int           pos;
      int           j;
      bit           hit;
      rec_t         merged [MaxRecords+1];
      leaf_result_t moved;
      pos = 0;
      while (pos < fill && orders_before(recs[pos], r)) pos++;
      hit = 1'b0;
      if (pos < fill) hit = (recs[pos] == r);

      if (op == REQ_DELETE) begin
        if (!hit) begin
          push_single(ST_NOTFOUND);
        end else begin
          for (int i = pos; i + 1 < fill; i++) recs[i] = recs[i+1];
          fill--;
          push_single(ST_DELETED);
        end
      end else if (hit) begin
        push_single(ST_DUPLICATE);
      end else if (fill < MaxRecords) begin
        for (int i = fill; i > pos; i--) recs[i] = recs[i-1];
        recs[pos] = r;
        fill++;
        push_single(ST_INSERTED);
      end else begin
        // full leaf: merge, keep the lower half, stream the upper half
        j = 0;
        for (int i = 0; i <= MaxRecords; i++) begin
          if (i == pos) begin
            merged[i] = r;
          end else begin
            merged[i] = recs[j];
            j++;
          end
        end
        for (int i = 0; i < MidRecords; i++) recs[i] = merged[i];
        for (int i = MidRecords; i <= MaxRecords; i++) begin
          moved.status = ST_SPLIT;
          moved.key    = merged[i].key;
          moved.page   = merged[i].page;
          moved.slot   = merged[i].slot;
          moved.nxt    = next_ptr;
          moved.last   = (i == MaxRecords);
          awaited.insert(awaited.size(), moved);
        end
        fill     = MidRecords;
        next_ptr = {1'b0, fresh};
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= 100) $display("[%0t] error: %s", $time, what);
    endtask

    // Compare one accepted result against the oldest owed one
    task match_result(leaf_result_t got);
      leaf_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result status %0d", got.status));
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.key !== want.key)
        report($sformatf("out_key %h, want %h", got.key, want.key));
      if (got.page !== want.page)
        report($sformatf("out_page %h, want %h", got.page, want.page));
      if (got.slot !== want.slot)
        report($sformatf("out_slot %h, want %h", got.slot, want.slot));
      if (got.nxt !== want.nxt)
        report($sformatf("out_next %h, want %h", got.nxt, want.nxt));
      if (got.last !== want.last)
        report($sformatf("last %b, want %b", got.last, want.last));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   calm = 1'b0;
  int   quiet_cycles = 0;

  leaf_tracker leaf = new();

  slid_req_if req_if ();
  slid_res_if res_if ();

  sorted_leaf_insert_delete_split uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  always #5 clk_i = ~clk_i;

  // Sample both channels at each edge; one process keeps request/result order fixed
  always @(posedge clk_i) begin : monitor
    leaf_result_t seen;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready)
        leaf.apply_request(req_type_e'(req_if.req_type),
                           rec_t'({req_if.rec_key, req_if.rec_page, req_if.rec_slot}),
                           req_if.fresh_page);
      if (res_if.valid && res_if.ready) begin
        seen.status = res_if.status;
        seen.key    = res_if.out_key;
        seen.page   = res_if.out_page;
        seen.slot   = res_if.out_slot;
        seen.nxt    = res_if.out_next;
        seen.last   = res_if.last;
        leaf.match_result(seen);
      end
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side back-pressure in random bursts
  initial begin : result_sink
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    do @(posedge clk_i); while (quiet_cycles < QuietLimit);
    $display("sorted_leaf_insert_delete_split: mismatch");
    $finish;
  end

  // Present one request and hold it until accepted; maybe idle afterwards
  task automatic send_request(req_type_e op, logic signed [KeyW-1:0] key,
                              logic [PageW-1:0] page, logic [SlotW-1:0] slot,
                              logic [PageW-1:0] fresh);
    req_if.valid      <= 1'b1;
    req_if.req_type   <= op;
    req_if.rec_key    <= key;
    req_if.rec_page   <= page;
    req_if.rec_slot   <= slot;
    req_if.fresh_page <= fresh;
    do @(posedge clk_i); while (!req_if.ready);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // Hold off the sender until every owed result has arrived
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (leaf.awaited.size() != 0);
  endtask

  function automatic logic signed [KeyW-1:0] pick_key();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(KeyW-1){1'b0}}};
      1: return {1'b0, {(KeyW-1){1'b1}}};
      2: return $signed({$urandom(), $urandom()}) >>> 60;  // small keys, many ties
      3: begin
        if (leaf.fill != 0) return leaf.recs[$urandom_range(0, leaf.fill - 1)].key;
        return '0;
      end
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [PageW-1:0] pick_id();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return PageW'($urandom_range(0, 3));
      default: return PageW'($urandom());
    endcase
  endfunction

  // One random request, mostly fresh inserts so the leaf fills and splits
  task automatic random_request();
    int unsigned      roll;
    rec_t             old_rec;
    logic [PageW-1:0] fresh;
    roll = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0:       fresh = '0;
      1:       fresh = '1;
      default: fresh = PageW'($urandom());
    endcase
    if (leaf.fill != 0) old_rec = leaf.recs[$urandom_range(0, leaf.fill - 1)];
    else old_rec = '{pick_key(), pick_id(), pick_id()};
    if (roll < 66)
      send_request(REQ_INSERT, pick_key(), pick_id(), pick_id(), fresh);
    else if (roll < 74)
      send_request(REQ_INSERT, old_rec.key, old_rec.page, old_rec.slot, fresh);
    else if (roll < 88)
      send_request(REQ_DELETE, old_rec.key, old_rec.page, old_rec.slot, fresh);
    else if (roll < 95)
      send_request(REQ_DELETE, old_rec.key, old_rec.page, old_rec.slot ^ SlotW'(1), fresh);
    else
      send_request(req_type_e'($urandom_range(0, 1)), {$urandom(), $urandom()},
                   PageW'($urandom()), SlotW'($urandom()), fresh);
  endtask

  initial begin : stimulus
    rst_ni = 1'b0;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_INSERT;
    req_if.rec_key    <= '0;
    req_if.rec_page   <= '0;
    req_if.rec_slot   <= '0;
    req_if.fresh_page <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty leaf, extremes, tie-breaks, near misses, first/last deletes
    send_request(REQ_DELETE, '0, '0, '0, '0);
    send_request(REQ_INSERT, '0, '0, '0, '0);
    send_request(REQ_INSERT, '0, '0, '0, '1);
    send_request(REQ_INSERT, {1'b1, {(KeyW-1){1'b0}}}, '1, '1, '0);
    send_request(REQ_INSERT, {1'b0, {(KeyW-1){1'b1}}}, '0, '1, '0);
    send_request(REQ_INSERT, -64'sd1, 31'd5, 31'd7, '0);
    send_request(REQ_INSERT, -64'sd1, 31'd5, 31'd6, '0);
    send_request(REQ_INSERT, -64'sd1, 31'd4, 31'd9, '0);
    send_request(REQ_INSERT, 64'sd1, '1, '0, '0);
    send_request(REQ_DELETE, -64'sd1, 31'd5, 31'd8, '0);
    send_request(REQ_DELETE, -64'sd1, 31'd5, 31'd7, '0);
    send_request(REQ_DELETE, {1'b1, {(KeyW-1){1'b0}}}, '1, '1, '0);
    send_request(REQ_DELETE, {1'b0, {(KeyW-1){1'b1}}}, '0, '1, '0);
    send_request(REQ_DELETE, {1'b0, {(KeyW-1){1'b1}}}, '0, '1, '0);
    send_request(REQ_INSERT, -64'sd1, 31'd5, 31'd6, '0);
    send_request(REQ_INSERT, {1'b0, {(KeyW-1){1'b1}}}, '1, '1, '0);
    send_request(REQ_INSERT, {1'b1, {(KeyW-1){1'b0}}}, '0, '0, '0);
    drain();

    // random traffic with a few full drains along the way
    for (int n = 0; n < RandomItems; n++) begin
      if (n == 70 || n == 150) drain();
      if (n == RandomItems - CalmItems) calm = 1'b1;
      random_request();
    end
    drain();
    repeat (SettleCycles) @(posedge clk_i);

    if (leaf.awaited.size() != 0)
      leaf.report($sformatf("%0d results never arrived", leaf.awaited.size()));
    if (leaf.errors == 0)
      $display("sorted_leaf_insert_delete_split: match");
    else
      $display("sorted_leaf_insert_delete_split: mismatch");
    $finish;
  end

endmodule
